// ===== hdl/gcca_pkg.sv =====
// ----------------------------------------------------------------------------
// gcca_pkg: shared types, constants and table functions
// Fixed-point formats and CORDIC arctangent table for the central angle block.
// ----------------------------------------------------------------------------
package gcca_pkg;

  // CORDIC datapath width, Q30 values with headroom for vector growth
  localparam int CW    = 36;
  localparam int ITERS = 31;

  typedef logic signed [CW-1:0] cq_t;
  typedef logic [63:0]          bang_t;

  localparam cq_t   GAIN_Q30       = cq_t'(36'sh0_26DD3B6A);
  localparam bang_t PI_Q60         = 64'h3243F6A8885A308D;
  localparam bang_t INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam bang_t QUARTER_TURN   = 64'h4000000000000000;
  localparam bang_t HALF_TURN      = 64'h8000000000000000;

  // Shift-subtract unsigned division, elaboration use only
  function automatic bang_t udiv64(bang_t n, bang_t d);
    bang_t q;
    bang_t rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in 2^-64 turn units, built from the arctangent series in Q62
  function automatic bang_t atan_entry(int i);
    bang_t              a;
    logic signed [63:0] s;
    logic signed [63:0] t;
    logic [127:0]       prod;
    bang_t              a2;
    s = '0;
    if (i == 0) begin
      a = PI_Q60;
    end else begin
      for (int k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          t = signed'(udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1)));
          s = (k % 2 == 1) ? s - t : s + t;
        end
      end
      a = bang_t'(s);
    end
    a2   = a << 1;
    prod = {64'd0, a2} * {64'd0, INV_TWO_PI_Q64};
    return prod[127:64] << 1;
  endfunction

  // Q30 product, floored
  function automatic cq_t qmul(cq_t a, cq_t b);
    logic signed [2*CW-1:0] pr;
    pr = a * b;
    return pr[CW+29:30];
  endfunction

endpackage

// ===== hdl/gcca_sincos.sv =====
// ----------------------------------------------------------------------------
// gcca_sincos: pipelined rotation-mode CORDIC
// Sine and cosine of a 64-bit binary angle in Q30, one angle per cycle while en is high.
// ----------------------------------------------------------------------------
module gcca_sincos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   ang,
  output logic          out_valid,
  output gcca_pkg::cq_t sin_q,
  output gcca_pkg::cq_t cos_q
);
  import gcca_pkg::*;

  logic  flip0_r;
  logic  vld0_r;
  bang_t z0_r;

  cq_t   x_r    [ITERS];
  cq_t   y_r    [ITERS];
  bang_t z_r    [ITERS];
  logic  flip_r [ITERS];
  logic  vld_r  [ITERS];

  cq_t   sin_r;
  cq_t   cos_r;
  logic  out_vld_r;

  logic  flip_nxt;

  // Fold the angle into the right half plane
  assign flip_nxt = (ang[63:62] == 2'b01) || (ang[63:62] == 2'b10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flip0_r <= flip_nxt;
      z0_r    <= flip_nxt ? ang + HALF_TURN : ang;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam bang_t ATAN_I = atan_entry(i);
    cq_t   xi;
    cq_t   yi;
    bang_t zi;
    logic  fi;
    logic  vi;
    if (i == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = z0_r;
      assign fi = flip0_r;
      assign vi = vld0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flip_r[i-1];
      assign vi = vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i] <= fi;
        if (!zi[63]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_I;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_I;
        end
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[ITERS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= flip_r[ITERS-1] ? -x_r[ITERS-1] : x_r[ITERS-1];
      sin_r <= flip_r[ITERS-1] ? -y_r[ITERS-1] : y_r[ITERS-1];
    end
  end

  assign out_valid = out_vld_r;
  assign sin_q     = sin_r;
  assign cos_q     = cos_r;

endmodule

// ===== hdl/gcca_atan2.sv =====
// ----------------------------------------------------------------------------
// gcca_atan2: pipelined vectoring-mode CORDIC
// Angle of the vector (x, y) as a 64-bit binary angle, one vector per cycle while en is high.
// ----------------------------------------------------------------------------
module gcca_atan2 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  gcca_pkg::cq_t y_in,
  input  gcca_pkg::cq_t x_in,
  output logic          out_valid,
  output logic [63:0]   z_out
);
  import gcca_pkg::*;

  cq_t   x0_r;
  cq_t   y0_r;
  bang_t z0_r;
  logic  vld0_r;

  cq_t   x_r   [ITERS];
  cq_t   y_r   [ITERS];
  bang_t z_r   [ITERS];
  logic  vld_r [ITERS];

  // Pre-rotate by a quarter turn when x is negative
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        x0_r <= y_in;
        y0_r <= -x_in;
        z0_r <= QUARTER_TURN;
      end else begin
        x0_r <= x_in;
        y0_r <= y_in;
        z0_r <= '0;
      end
    end
  end

  // Drive y towards zero, one stage per iteration
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam bang_t ATAN_I = atan_entry(i);
    cq_t   xi;
    cq_t   yi;
    bang_t zi;
    logic  vi;
    if (i == 0) begin : g_first
      assign xi = x0_r;
      assign yi = y0_r;
      assign zi = z0_r;
      assign vi = vld0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi >= 0) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_I;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_I;
        end
      end
    end
  end

  assign out_valid = vld_r[ITERS-1];
  assign z_out     = z_r[ITERS-1];

endmodule

// ===== hdl/great_circle_central_angle_top.sv =====
// Path: input register, sine/cosine CORDICs, products, integer root, atan2 CORDIC, output.
// Throughput: one point pair per cycle while the output is not stalled; every stage is a register, so a new item enters
// each cycle and the three sine/cosine CORDICs run side by side.
// A one-item skid register takes an input while the output waits; a stall freezes all.
// Reset (rst_n low, synchronous) clears all valid bits; no data registers are reset.
// ----------------------------------------------------------------------------
// great_circle_central_angle_top: spherical central angle between two points
// CORDIC sine/cosine, Q30 products, pipelined integer root, CORDIC atan2.
// ----------------------------------------------------------------------------
module great_circle_central_angle_top #(
  parameter int ANGLE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // lat_a, lon_a, lat_b, lon_b, ANGLE_BITS each, from bit 0 up
  input  logic [((4*ANGLE_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // central_angle, ANGLE_BITS, from bit 0 up
  output logic [((ANGLE_BITS+7)/8)*8-1:0]         out_tdata
);
  import gcca_pkg::*;

  localparam int AB     = ANGLE_BITS;
  localparam int IN_W   = ((4*AB+7)/8)*8;
  localparam int OUT_W  = ((AB+7)/8)*8;
  localparam int UP     = 64 - AB;
  localparam int SQ_N   = 32;
  localparam bang_t RND = bang_t'(64'd1 << (UP-1));

  logic            en;
  logic            in_fire;
  logic            skid_valid_r;
  logic [IN_W-1:0] skid_data_r;
  logic [IN_W-1:0] src_data;

  bang_t la_nxt, lb_nxt, la0_nxt, lb0_nxt, dl_nxt;
  bang_t la_r, lb_r, dl_r;
  logic  v0_r;

  cq_t   sa, ca, sb, cb, sd, cd;
  logic  sva, svb, svd;

  // Product stages
  logic  pv_r [5];
  cq_t   p1_r, t1_r, t2_r, t3_r, t4_r, cd1_r;
  cq_t   p2_r, t1b_r, t3b_r, u2_r, u4_r;
  cq_t   p3_r, q3_r, r3_r;
  logic signed [2*CW-1:0] pp_w, qq_w;
  bang_t pp_r, qq_r;
  cq_t   r4_r;
  bang_t m2_r;
  cq_t   r5_r;

  // Root stages
  bang_t sq_v_r   [SQ_N];
  bang_t sq_res_r [SQ_N];
  cq_t   sq_r_r   [SQ_N];
  logic  sq_vld_r [SQ_N];

  logic  at_vld;
  bang_t at_z;
  bang_t zc;
  bang_t zr;

  logic          out_tvalid_r;
  logic [AB-1:0] out_data_r;

  // Advance the whole pipeline unless a result waits
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign src_data  = skid_valid_r ? skid_data_r : in_tdata;

  // Hold one item while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_data_r <= in_tdata;
    end
  end

  // Widen fields to 64-bit binary angles and form the longitude difference
  assign la_nxt  = {src_data[AB-1:0],      {UP{1'b0}}};
  assign la0_nxt = {src_data[2*AB-1:AB],   {UP{1'b0}}};
  assign lb_nxt  = {src_data[3*AB-1:2*AB], {UP{1'b0}}};
  assign lb0_nxt = {src_data[4*AB-1:3*AB], {UP{1'b0}}};
  assign dl_nxt  = lb0_nxt - la0_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= skid_valid_r || in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r <= la_nxt;
      lb_r <= lb_nxt;
      dl_r <= dl_nxt;
    end
  end

  gcca_sincos u_sc_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v0_r), .ang(la_r),
    .out_valid(sva), .sin_q(sa), .cos_q(ca)
  );

  gcca_sincos u_sc_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v0_r), .ang(lb_r),
    .out_valid(svb), .sin_q(sb), .cos_q(cb)
  );

  gcca_sincos u_sc_d (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v0_r), .ang(dl_r),
    .out_valid(svd), .sin_q(sd), .cos_q(cd)
  );

  // Advance product valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) pv_r[k] <= 1'b0;
    end else if (en) begin
      pv_r[0] <= sva;
      for (int k = 1; k < 5; k++) pv_r[k] <= pv_r[k-1];
    end
  end

  // Square p and q at full width
  assign pp_w = p3_r * p3_r;
  assign qq_w = q3_r * q3_r;

  // Form p, q, r and the squared magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= qmul(cb, sd);
      t1_r  <= qmul(ca, sb);
      t2_r  <= qmul(sa, cb);
      t3_r  <= qmul(sa, sb);
      t4_r  <= qmul(ca, cb);
      cd1_r <= cd;

      p2_r  <= p1_r;
      t1b_r <= t1_r;
      t3b_r <= t3_r;
      u2_r  <= qmul(t2_r, cd1_r);
      u4_r  <= qmul(t4_r, cd1_r);

      p3_r  <= p2_r;
      q3_r  <= t1b_r - u2_r;
      r3_r  <= t3b_r + u4_r;

      pp_r  <= pp_w[63:0];
      qq_r  <= qq_w[63:0];
      r4_r  <= r3_r;

      m2_r  <= pp_r + qq_r;
      r5_r  <= r4_r;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam bang_t BIT_K = bang_t'(64'd1 << (62 - 2*k));
    bang_t vi;
    bang_t ri;
    bang_t trial;
    cq_t   rri;
    logic  vvi;
    if (k == 0) begin : g_first
      assign vi  = m2_r;
      assign ri  = '0;
      assign rri = r5_r;
      assign vvi = pv_r[4];
    end else begin : g_next
      assign vi  = sq_v_r[k-1];
      assign ri  = sq_res_r[k-1];
      assign rri = sq_r_r[k-1];
      assign vvi = sq_vld_r[k-1];
    end
    assign trial = ri + BIT_K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k] <= vvi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r_r[k] <= rri;
        if (vi >= trial) begin
          sq_v_r[k]   <= vi - trial;
          sq_res_r[k] <= (ri >> 1) + BIT_K;
        end else begin
          sq_v_r[k]   <= vi;
          sq_res_r[k] <= ri >> 1;
        end
      end
    end
  end

  gcca_atan2 u_atan2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_vld_r[SQ_N-1]),
    .y_in(cq_t'(sq_res_r[SQ_N-1][31:0])), .x_in(sq_r_r[SQ_N-1]),
    .out_valid(at_vld), .z_out(at_z)
  );

  // Clamp to [0, half turn] and round half up
  always_comb begin
    if (at_z[63:62] == 2'b11) begin
      zc = '0;
    end else if (at_z > HALF_TURN) begin
      zc = HALF_TURN;
    end else begin
      zc = at_z;
    end
    zr = (zc + RND) >> UP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= at_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= zr[AB-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // The three sine/cosine pipelines stay in step
  a_sc_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (sva == svb) && (svb == svd))
    else $error("sine/cosine pipelines out of step");

  // A result never exceeds half a turn
  a_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_data_r <= (AB'(1) << (AB-1))))
    else $error("central angle above half turn");

  // The skid register fills only while the pipeline is stalled
  a_skid_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(!en))
    else $error("skid filled while pipeline advanced");

  // Nothing is valid straight after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_tvalid_r && !skid_valid_r && !v0_r))
    else $error("valid bit survived reset");

endmodule
